// File: src/ped_pkg.sv
// Shared types, constants and helper functions for the percent escape decoder.
package ped_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // One queued result.
    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       run_last;
        logic       string_end;
    } res_entry_t;

    // Returns {not_hex, nibble}; not_hex is set when the byte is no hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b0, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b0, 4'(b - 8'h61 + 8'd10)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b0, 4'(b - 8'h41 + 8'd10)};
        end
        return r;
    endfunction

    function automatic res_entry_t mk_entry(input logic [7:0] ch, input logic cv);
        res_entry_t e;
        e.ch         = ch;
        e.cv         = cv;
        e.run_last   = 1'b0;
        e.string_end = 1'b0;
        return e;
    endfunction

endpackage

// File: src/percent_escape_decoder.sv
// Streaming percent-escape decoder: input register, decode logic and result queue.
//
// Usage: raw bytes enter on in_char with in_final set on the last byte of a
// string. A request is taken at a rising edge of clk where in_valid is high
// and in_stall is low; results leave the same way on out_valid/out_stall.
// Each input byte gives zero to three results. Every result carries out_char,
// char_valid (low for a bare end marker), run_last (last result of that byte)
// and string_end (last result of the whole string).
// A byte is registered at acceptance and decoded into a four-entry result queue
// once that queue holds at most one result. Throughput is one byte per cycle
// while each byte gives at most one result and out_stall stays low; the queue
// drains one result per cycle while out_stall is low, so a byte that gives two
// or three results holds the next byte back until at most one result is queued.
// in_stall comes from registers only and rises when the queue holds more than one
// result while a byte waits in the input register.
// Reset (rst_n low) empties the queue and the input register and returns the
// decoder to idle with no escape pending. When the receiver stalls, the head
// result stays on the output ports unchanged and input is stalled once the
// queue cannot take another burst.
module percent_escape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_final,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       run_last,
    output logic       string_end
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIGIT,
        PH_DONE
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] char_reg;
    logic       final_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [1:0] wptr_reg, wptr_next;

    ped_pkg::res_entry_t q_reg [4];
    ped_pkg::res_entry_t res [3];
    logic [1:0] res_n;

    logic       accept;
    logic       advance;
    logic       pop;
    logic [4:0] hb;
    logic [4:0] hh;
    logic [7:0] dec_val;

    assign in_stall = s1_valid_reg && (cnt_reg > 3'd1);
    assign accept   = in_valid && !in_stall;
    assign advance  = s1_valid_reg && (cnt_reg <= 3'd1);
    assign out_valid = (cnt_reg != 3'd0);
    assign pop       = out_valid && !out_stall;

    assign out_char   = q_reg[rptr_reg].ch;
    assign char_valid = q_reg[rptr_reg].cv;
    assign run_last   = q_reg[rptr_reg].run_last;
    assign string_end = q_reg[rptr_reg].string_end;

    assign hb      = ped_pkg::hex_nibble(char_reg);
    assign hh      = ped_pkg::hex_nibble(held_reg);
    assign dec_val = {hh[3:0], hb[3:0]};

    // Decode of the registered byte against the pending escape.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        res_n      = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = ped_pkg::mk_entry(8'h00, 1'b0);
        end
        if (final_reg)
        begin
            unique case (phase_reg)
                PH_PCT:
                begin
                    res_n  = 2'd2;
                    res[0] = ped_pkg::mk_entry(ped_pkg::PCT_CHAR, 1'b1);
                    res[1] = ped_pkg::mk_entry(char_reg, 1'b1);
                end
                PH_DIGIT:
                begin
                    if (!hb[4])
                    begin
                        res_n = 2'd1;
                        // An escape that decodes to zero leaves only the end marker.
                        if (dec_val != 8'h00)
                        begin
                            res[0] = ped_pkg::mk_entry(dec_val, 1'b1);
                        end
                    end
                    else
                    begin
                        res_n  = 2'd3;
                        res[0] = ped_pkg::mk_entry(ped_pkg::PCT_CHAR, 1'b1);
                        res[1] = ped_pkg::mk_entry(held_reg, 1'b1);
                        res[2] = ped_pkg::mk_entry(char_reg, 1'b1);
                    end
                end
                PH_DONE:
                begin
                    res_n = 2'd1;
                end
                PH_IDLE:
                begin
                    res_n  = 2'd1;
                    res[0] = ped_pkg::mk_entry(char_reg, 1'b1);
                end
                default:
                begin
                    res_n = 2'd1;
                end
            endcase
            phase_next = PH_IDLE;
            held_next  = 8'h00;
        end
        else
        begin
            unique case (phase_reg)
                PH_DONE:
                begin
                    res_n = 2'd0;
                end
                PH_DIGIT:
                begin
                    if (!hb[4])
                    begin
                        if (dec_val == 8'h00)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            res_n      = 2'd1;
                            res[0]     = ped_pkg::mk_entry(dec_val, 1'b1);
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        // The failed escape goes out literally and the byte is looked at again.
                        res[0] = ped_pkg::mk_entry(ped_pkg::PCT_CHAR, 1'b1);
                        res[1] = ped_pkg::mk_entry(held_reg, 1'b1);
                        if (char_reg == ped_pkg::PCT_CHAR)
                        begin
                            res_n      = 2'd2;
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            res_n      = 2'd3;
                            res[2]     = ped_pkg::mk_entry(char_reg, 1'b1);
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_PCT:
                begin
                    if (!hb[4])
                    begin
                        held_next  = char_reg;
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        res[0] = ped_pkg::mk_entry(ped_pkg::PCT_CHAR, 1'b1);
                        if (char_reg == ped_pkg::PCT_CHAR)
                        begin
                            res_n      = 2'd1;
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            res_n      = 2'd2;
                            res[1]     = ped_pkg::mk_entry(char_reg, 1'b1);
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_IDLE:
                begin
                    if (char_reg == ped_pkg::PCT_CHAR)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        res_n  = 2'd1;
                        res[0] = ped_pkg::mk_entry(char_reg, 1'b1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        for (int i = 0; i < 3; i++)
        begin
            res[i].run_last   = (2'(i + 1) == res_n);
            res[i].string_end = final_reg && (2'(i + 1) == res_n);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        cnt_next  = cnt_reg - {2'b00, pop} + (advance ? {1'b0, res_n} : 3'd0);
        rptr_next = rptr_reg + {1'b0, pop};
        wptr_next = wptr_reg + (advance ? res_n : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            s1_valid_reg <= 1'b0;
            cnt_reg      <= 3'd0;
            rptr_reg     <= 2'd0;
            wptr_reg     <= 2'd0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
            end
            s1_valid_reg <= s1_valid_next;
            cnt_reg      <= cnt_next;
            rptr_reg     <= rptr_next;
            wptr_reg     <= wptr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 8'h00;
        end
        else if (advance)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= in_char;
            final_reg <= in_final;
        end
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < res_n)
                begin
                    q_reg[wptr_reg + 2'(i)] <= res[i];
                end
            end
        end
    end

endmodule

// File: verif/tb_percent_escape_decoder.sv
// Self-checking testbench for the streaming percent escape decoder.
module tb_percent_escape_decoder;

    localparam int N_ITEMS    = 480;
    localparam int TAIL_ITEMS = 70;
    localparam int LONG_HOLD  = 60;
    localparam int MAX_CYCLES = 200000;

    typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT, PH_DONE} dec_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       run_last;
        logic       string_end;
    } dec_out_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         drain;
    } raw_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_char = 8'h00;
    logic       in_final = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       string_end;

    raw_byte_t  raw_q[$];
    dec_out_t   expected_q[$];

    dec_phase_t dec_phase = PH_IDLE;
    logic [7:0] dec_held = 8'h00;

    int  n_accepted = 0;
    int  n_strings = 0;
    int  n_cutoffs = 0;
    int  n_results = 0;
    int  n_errors = 0;
    int  n_cycles = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  calm = 1'b0;

    percent_escape_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_char    (in_char),
        .in_final   (in_final),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .char_valid (char_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Returns {not_hex, value}.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
        begin
            return {1'b0, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    function automatic dec_out_t out_item(input logic [7:0] ch, input logic cv);
        dec_out_t e;
        e.ch         = ch;
        e.cv         = cv;
        e.run_last   = 1'b0;
        e.string_end = 1'b0;
        return e;
    endfunction

    // Advances the decoder state by one byte and queues the results it gives.
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        dec_out_t   outs[$];
        logic [4:0] nb;
        logic [4:0] hh;
        logic [7:0] v;
        bit         as_idle;
        nb = hex_val(b);
        hh = hex_val(dec_held);
        v = {hh[3:0], nb[3:0]};
        as_idle = 1'b0;
        if (fin)
        begin
            case (dec_phase)
                PH_PCT:
                begin
                    outs = {outs, out_item(ped_pkg::PCT_CHAR, 1'b1)};
                    outs = {outs, out_item(b, 1'b1)};
                end
                PH_DIGIT:
                begin
                    if (!nb[4])
                    begin
                        if (v == 8'h00)
                        begin
                            outs = {outs, out_item(8'h00, 1'b0)};
                            n_cutoffs++;
                        end
                        else
                        begin
                            outs = {outs, out_item(v, 1'b1)};
                        end
                    end
                    else
                    begin
                        outs = {outs, out_item(ped_pkg::PCT_CHAR, 1'b1)};
                        outs = {outs, out_item(dec_held, 1'b1)};
                        outs = {outs, out_item(b, 1'b1)};
                    end
                end
                PH_DONE:
                begin
                    outs = {outs, out_item(8'h00, 1'b0)};
                end
                default:
                begin
                    outs = {outs, out_item(b, 1'b1)};
                end
            endcase
            outs[outs.size() - 1].string_end = 1'b1;
            dec_phase = PH_IDLE;
            dec_held = 8'h00;
            n_strings++;
        end
        else if (dec_phase != PH_DONE)
        begin
            if (dec_phase == PH_DIGIT)
            begin
                if (!nb[4])
                begin
                    // A decoded zero byte cuts the string off silently.
                    if (v == 8'h00)
                    begin
                        dec_phase = PH_DONE;
                        n_cutoffs++;
                    end
                    else
                    begin
                        outs = {outs, out_item(v, 1'b1)};
                        dec_phase = PH_IDLE;
                    end
                end
                else
                begin
                    outs = {outs, out_item(ped_pkg::PCT_CHAR, 1'b1)};
                    outs = {outs, out_item(dec_held, 1'b1)};
                    as_idle = 1'b1;
                end
                dec_held = 8'h00;
            end
            else if (dec_phase == PH_PCT)
            begin
                if (!nb[4])
                begin
                    dec_held = b;
                    dec_phase = PH_DIGIT;
                end
                else
                begin
                    outs = {outs, out_item(ped_pkg::PCT_CHAR, 1'b1)};
                    as_idle = 1'b1;
                end
            end
            else
            begin
                as_idle = 1'b1;
            end
            // The byte after a broken escape is looked at again from idle.
            if (as_idle)
            begin
                if (b == ped_pkg::PCT_CHAR)
                begin
                    dec_phase = PH_PCT;
                end
                else
                begin
                    outs = {outs, out_item(b, 1'b1)};
                    dec_phase = PH_IDLE;
                end
            end
        end
        if (outs.size() > 0)
        begin
            outs[outs.size() - 1].run_last = 1'b1;
        end
        expected_q = {expected_q, outs};
    endfunction

    // Sender: offers queued bytes, with random gaps outside the calm stretches.
    always @(posedge clk or negedge rst_n)
    begin
        raw_byte_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_char <= 8'h00;
            in_final <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_char, in_final);
                n_accepted++;
            end
            calm = (raw_q.size() < TAIL_ITEMS) || ((n_accepted / 60) % 4 == 3);
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (raw_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (raw_q[0].drain && expected_q.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(1, 10) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    it = raw_q.pop_front();
                    in_valid <= 1'b1;
                    in_char <= it.ch;
                    in_final <= it.fin;
                end
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold that backs up the block.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (!hold_done && n_accepted >= 180)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        dec_out_t got;
        dec_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {out_char, char_valid, run_last, string_end};
            n_results++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: expected nothing, got char/cv/last/end %02h %b %b %b",
                         $time, got.ch, got.cv, got.run_last, got.string_end);
                n_errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected char/cv/last/end %02h %b %b %b, got %02h %b %b %b",
                             $time, want.ch, want.cv, want.run_last, want.string_end,
                             got.ch, got.cv, got.run_last, got.string_end);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > MAX_CYCLES)
        begin
            $display("%0t: timeout with %0d results still expected", $time, expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fin, input bit drain);
        raw_byte_t it;
        it.ch    = b;
        it.fin   = fin;
        it.drain = drain;
        raw_q = {raw_q, it};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i], i == s.len() - 1, 1'b0);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
        begin
            return 8'h30 + n;
        end
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] b;
        logic [4:0] hv;
        b = 8'h30;
        hv = hex_val(b);
        while (!hv[4])
        begin
            case ($urandom_range(0, 3))
                0: b = 8'($urandom_range(0, 255));
                1: b = 8'h2F + 8'($urandom_range(0, 1) * 11);
                2: b = 8'h40 + 8'($urandom_range(0, 1) * 7);
                default: b = 8'h60 + 8'($urandom_range(0, 1) * 7);
            endcase
            hv = hex_val(b);
        end
        return b;
    endfunction

    initial
    begin
        logic [7:0] txt[$];
        logic [7:0] near_hex[$];
        int         len;
        int         sel;
        bit         drain_set;
        near_hex = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h25,
                     8'h30, 8'h39, 8'h41, 8'h46, 8'h61, 8'h66};
        drain_set = 1'b0;

        // Directed strings: escapes in both cases, broken escapes, a %00 cut-off,
        // and each way the final byte can flush what is pending.
        add_text("%4Fz");
        add_text("%6f%4g");
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        add_text("%%41");
        add_text("%00xy");
        add_text("%00");
        add_text("%");
        add_text("%A");

        while (raw_q.size() < N_ITEMS)
        begin
            txt.delete();
            len = $urandom_range(1, 12);
            while (txt.size() < len)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 35)
                begin
                    txt = {txt, 8'($urandom_range(0, 255))};
                end
                else if (sel < 60)
                begin
                    txt = {txt, ped_pkg::PCT_CHAR};
                    if ($urandom_range(0, 9) == 0)
                    begin
                        txt = {txt, 8'h30, 8'h30};
                    end
                    else
                    begin
                        txt = {txt, hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1)))};
                        txt = {txt, hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1)))};
                    end
                end
                else if (sel < 72)
                begin
                    txt = {txt, ped_pkg::PCT_CHAR};
                    if ($urandom_range(0, 1) == 1)
                    begin
                        txt = {txt, hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1)))};
                    end
                    txt = {txt, pick_nonhex()};
                end
                else if (sel < 80)
                begin
                    txt = {txt, ped_pkg::PCT_CHAR};
                end
                else
                begin
                    txt = {txt, near_hex[$urandom_range(0, near_hex.size() - 1)]};
                end
            end
            foreach (txt[i])
            begin
                // Once mid-run the sender waits for the output to run dry first.
                push_byte(txt[i], i == txt.size() - 1,
                          i == 0 && !drain_set && raw_q.size() >= 260);
            end
            if (raw_q.size() >= 260)
            begin
                drain_set = 1'b1;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (raw_q.size() > 0 || in_valid || expected_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d strings, checked %0d results, %0d cut off by %%00.",
                 n_accepted, n_strings, n_results, n_cutoffs);
        $display("Run mixed escapes, broken escapes, final flushes and stalls on both sides.");
        if (n_errors == 0 && expected_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
